// ===== hdl/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants and codes for the LCS column engine and its cells.
// ----------------------------------------------------------------------------
package lcs_pkg;

  // Default bounds on the two strings
  localparam int unsigned MaxFirst  = 16;
  localparam int unsigned MaxSecond = 255;

  // Fixed field widths
  localparam int unsigned SymW      = 8;
  localparam int unsigned ColIdxW   = 8;
  localparam int unsigned LenOutW   = 5;
  localparam int unsigned DirW      = 2;
  localparam int unsigned DirRowsW  = 16;   // rows that fit in the directions field

  // Request codes
  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_COLUMN = 1'b1
  } req_e;

  // Traceback direction codes
  typedef enum logic [DirW-1:0] {
    DIR_DIAG = 2'd0,
    DIR_UP   = 2'd1,
    DIR_LEFT = 2'd2
  } dir_e;

endpackage

// ===== hdl/lcs_cell.sv =====
// ----------------------------------------------------------------------------
// lcs_cell
// One row of the DP column: holds a first-string symbol and its score, and
// passes the column wave on to the next row in the following cycle.
// ----------------------------------------------------------------------------
module lcs_cell #(
  parameter int unsigned ScoreW = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // symbol load
  input  logic                     wr_en_i,
  input  logic [lcs_pkg::SymW-1:0] wr_sym_i,
  // score clear (new column set)
  input  logic                     clear_i,
  // row holds a stored symbol
  input  logic                     present_i,
  // wave from the row above
  input  logic                     wave_valid_i,
  input  logic [lcs_pkg::SymW-1:0] wave_sym_i,
  input  logic [ScoreW-1:0]        wave_up_i,
  input  logic [ScoreW-1:0]        wave_diag_i,
  // wave to the row below
  output logic                     wave_valid_o,
  output logic [lcs_pkg::SymW-1:0] wave_sym_o,
  output logic [ScoreW-1:0]        wave_up_o,
  output logic [ScoreW-1:0]        wave_diag_o,
  // direction code of the latest column
  output lcs_pkg::dir_e            dir_o
);

  logic [lcs_pkg::SymW-1:0] sym_q;
  logic [ScoreW-1:0]        score_q, score_d;
  lcs_pkg::dir_e            dir_q, dir_d;
  logic                     valid_q;
  logic [lcs_pkg::SymW-1:0] osym_q;
  logic [ScoreW-1:0]        oup_q, oup_d;
  logic [ScoreW-1:0]        odiag_q;

  always_comb begin
    score_d = score_q;
    dir_d   = lcs_pkg::DIR_DIAG;
    oup_d   = wave_up_i;
    if (present_i) begin
      if (sym_q == wave_sym_i) begin
        score_d = wave_diag_i + ScoreW'(1);
        dir_d   = lcs_pkg::DIR_DIAG;
      end else if (wave_up_i >= score_q) begin
        score_d = wave_up_i;
        dir_d   = lcs_pkg::DIR_UP;
      end else begin
        score_d = score_q;
        dir_d   = lcs_pkg::DIR_LEFT;
      end
      oup_d = score_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      sym_q <= wr_sym_i;
    end
    if (wave_valid_i) begin
      osym_q  <= wave_sym_i;
      oup_q   <= oup_d;
      odiag_q <= score_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
      dir_q   <= lcs_pkg::DIR_DIAG;
      valid_q <= 1'b0;
    end else begin
      valid_q <= wave_valid_i;
      if (clear_i) begin
        score_q <= '0;
      end else if (wave_valid_i) begin
        score_q <= score_d;
      end
      if (wave_valid_i) begin
        dir_q <= dir_d;
      end
    end
  end

  assign wave_valid_o = valid_q;
  assign wave_sym_o   = osym_q;
  assign wave_up_o    = oup_q;
  assign wave_diag_o  = odiag_q;
  assign dir_o        = dir_q;

endmodule

// ===== hdl/lcs_dp_column_engine.sv =====
// ----------------------------------------------------------------------------
// lcs_dp_column_engine
// Longest common subsequence: one DP column per second-string symbol, worked
// out by a row of cells that each hold one first-string symbol.
// ----------------------------------------------------------------------------
// Use:
//   Command channel: a beat is taken at a rising edge with start_i high and
//   busy_o low. req_type_i selects a first-string load or a column request.
//   A load gives no result; busy_o stays low.
//   A column request raises busy_o; its wave walks down the cell row one
//   row per cycle and passes every cell (the row length, not the stored
//   string length, sets its path); the result is on the ports as the wave
//   leaves the last cell.
//   busy_o drops at the edge that ends the result cycle, so the next command
//   is taken at the edge after that at the earliest.
//   Result channel: done_o is high for exactly one cycle with the column
//   index, LCS length, packed direction codes, last and overflow flags.
//   The receiver cannot stall; a result must be taken in its cycle.
//   Reset (asynchronous, active low) empties the first string, clears all
//   scores, the column count and the overflow flag; stored symbols are not
//   cleared and are never read until written.
//   After the last column of a second string the scores and count clear so
//   another second string may follow against the same first string.
// ----------------------------------------------------------------------------
module lcs_dp_column_engine #(
  parameter int unsigned MAX_FIRST  = lcs_pkg::MaxFirst,
  parameter int unsigned MAX_SECOND = lcs_pkg::MaxSecond
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [lcs_pkg::SymW-1:0]      symbol_i,
  input  logic                          last_symbol_i,
  // result channel
  output logic                          done_o,
  output logic [lcs_pkg::ColIdxW-1:0]   column_index_o,
  output logic [lcs_pkg::LenOutW-1:0]   lcs_length_o,
  output logic [2*lcs_pkg::DirRowsW-1:0] directions_o,
  output logic                          last_column_o,
  output logic                          overflow_o
);

  localparam int unsigned ScoreW  = $clog2(MAX_FIRST + 1);
  localparam int unsigned FlenW   = $clog2(MAX_FIRST + 1);
  localparam int unsigned CntW    = $clog2(MAX_SECOND + 1);
  localparam int unsigned DirRows = (MAX_FIRST < lcs_pkg::DirRowsW) ? MAX_FIRST
                                                                     : lcs_pkg::DirRowsW;

  // control state
  logic [FlenW-1:0] flen_q, flen_d;
  logic             fdone_q, fdone_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             busy_q, busy_d;
  logic             last_q, last_d;

  logic             accept;
  logic             load_go;
  logic             col_go;
  logic             col_end;
  logic [FlenW-1:0] wr_idx;
  logic             wr_ok;
  logic             clear_scores;

  // chain wires: index k is the input of cell k, index MAX_FIRST the tail
  logic                     wv_valid [MAX_FIRST+1];
  logic [lcs_pkg::SymW-1:0] wv_sym   [MAX_FIRST+1];
  logic [ScoreW-1:0]        wv_up    [MAX_FIRST+1];
  logic [ScoreW-1:0]        wv_diag  [MAX_FIRST+1];
  lcs_pkg::dir_e            cell_dir [MAX_FIRST];

  assign accept  = start_i && !busy_q;
  assign load_go = accept && (req_type_i == lcs_pkg::REQ_LOAD);
  assign col_go  = accept && (req_type_i == lcs_pkg::REQ_COLUMN);
  assign col_end = wv_valid[MAX_FIRST];

  // a load after a completed string starts over at row 0
  assign wr_idx = fdone_q ? '0 : flen_q;
  assign wr_ok  = wr_idx < FlenW'(MAX_FIRST);

  assign clear_scores = (load_go && fdone_q) || (col_end && last_q);

  always_comb begin
    flen_d  = flen_q;
    fdone_d = fdone_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    busy_d  = busy_q;
    last_d  = last_q;
    if (load_go) begin
      if (fdone_q) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end
      if (wr_ok) begin
        flen_d = wr_idx + FlenW'(1);
      end else begin
        flen_d = wr_idx;
        ovf_d  = 1'b1;
      end
      fdone_d = last_symbol_i;
    end
    if (col_go) begin
      fdone_d = 1'b1;
      busy_d  = 1'b1;
      last_d  = last_symbol_i;
      if (cnt_q < CntW'(MAX_SECOND)) begin
        cnt_d = cnt_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (col_end) begin
      busy_d = 1'b0;
      if (last_q) begin
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q  <= '0;
      fdone_q <= 1'b0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      flen_q  <= flen_d;
      fdone_q <= fdone_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      busy_q  <= busy_d;
      last_q  <= last_d;
    end
  end

  // head of the chain: the column beat enters row 0 directly
  assign wv_valid[0] = col_go;
  assign wv_sym[0]   = symbol_i;
  assign wv_up[0]    = '0;
  assign wv_diag[0]  = '0;

  for (genvar k = 0; k < MAX_FIRST; k++) begin : g_row
    logic present;
    assign present = FlenW'(k) < flen_q;

    lcs_cell #(
      .ScoreW (ScoreW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .wr_en_i      (load_go && wr_ok && (wr_idx == FlenW'(k))),
      .wr_sym_i     (symbol_i),
      .clear_i      (clear_scores),
      .present_i    (present),
      .wave_valid_i (wv_valid[k]),
      .wave_sym_i   (wv_sym[k]),
      .wave_up_i    (wv_up[k]),
      .wave_diag_i  (wv_diag[k]),
      .wave_valid_o (wv_valid[k+1]),
      .wave_sym_o   (wv_sym[k+1]),
      .wave_up_o    (wv_up[k+1]),
      .wave_diag_o  (wv_diag[k+1]),
      .dir_o        (cell_dir[k])
    );
  end

  // only the first sixteen rows fit in the directions field
  for (genvar r = 0; r < DirRows; r++) begin : g_dir
    assign directions_o[lcs_pkg::DirW*r +: lcs_pkg::DirW] = cell_dir[r];
  end
  if (DirRows < lcs_pkg::DirRowsW) begin : g_dir_pad
    assign directions_o[2*lcs_pkg::DirRowsW-1:lcs_pkg::DirW*DirRows] = '0;
  end

  // tail of the chain carries the score of the last stored row
  assign done_o         = col_end;
  assign busy_o         = busy_q;
  assign column_index_o = lcs_pkg::ColIdxW'(cnt_q);
  assign lcs_length_o   = lcs_pkg::LenOutW'(wv_up[MAX_FIRST]);
  assign last_column_o  = last_q;
  assign overflow_o     = ovf_q;

endmodule
